// ===== hdl/sha512_pkg.sv =====
`timescale 1ns / 1ps
package sha512_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned Rounds = 80;

    typedef logic [WordW-1:0] t_word;

    localparam t_word InitHash [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam t_word RoundK [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [7:0] PadByte = 8'h80;

endpackage

// ===== hdl/sha512_round.sv =====
`timescale 1ns / 1ps
// One SHA-512 round and one schedule word, shared by all 80 rounds.
module sha512_round (
    input  sha512_pkg::t_word i_v [8],
    input  sha512_pkg::t_word i_w,
    input  sha512_pkg::t_word i_k,
    input  sha512_pkg::t_word i_w16,
    input  sha512_pkg::t_word i_w15,
    input  sha512_pkg::t_word i_w7,
    input  sha512_pkg::t_word i_w2,
    output sha512_pkg::t_word o_v [8],
    output sha512_pkg::t_word o_wnew
);
    import sha512_pkg::*;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    t_word s0, s1, t1, t2;

    always_comb begin
        s0 = rotr(i_w15, 1) ^ rotr(i_w15, 8) ^ (i_w15 >> 7);
        s1 = rotr(i_w2, 19) ^ rotr(i_w2, 61) ^ (i_w2 >> 6);
        o_wnew = i_w16 + s0 + i_w7 + s1;
        t1 = i_v[7] + (rotr(i_v[4], 14) ^ rotr(i_v[4], 18) ^ rotr(i_v[4], 41))
           + ((i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6])) + i_k + i_w;
        t2 = (rotr(i_v[0], 28) ^ rotr(i_v[0], 34) ^ rotr(i_v[0], 39))
           + ((i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]));
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + t2;
    end

endmodule

// ===== hdl/sha512_hash_core.sv =====
`timescale 1ns / 1ps
// SHA-512 hash core: one 64-bit message word per handshake, digest as eight words.
// A word that does not finish a block leaves the core ready for the next; the sixteenth
// word of a block goes through accept, load, one round a cycle and the state addition.
// The last word adds padding words at one a cycle plus one or two compressions, then
// eight digest words, one a cycle while m_axis_tready is high. Input waits until idle.
// Reset (i_rst_n low, synchronous) loads the initial hash values and clears counters.
module sha512_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // msg_word [63:0], byte_count [67:64], zeros
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // digest_word [63:0], word_index [66:64], zeros
    output logic        m_axis_tlast    // last_digest_word
);
    import sha512_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,  // waiting for a message word
        S_PAD   = 6'b000010,  // pushing padding words
        S_ROUND = 6'b000100,  // running the 80 rounds
        S_ADD   = 6'b001000,  // folding working words into the hash state
        S_OUT   = 6'b010000,  // presenting digest words
        S_LOAD  = 6'b100000   // copying the hash state into the working words
    } t_state;

    t_state r_state, n_state;
    t_word  r_h [8];
    t_word  r_v [8];
    t_word  r_w [16];
    logic [3:0]  r_pos;
    logic [63:0] r_len;
    logic [6:0]  r_rnd;
    logic        r_final;    // message ended; padding in progress or done
    logic        r_padded;   // the 0x80 byte has been placed
    logic        r_zero14;   // slot 14 of the current block holds a zero padding word
    logic [2:0]  r_oidx;

    // Set once the length word has been written into the block being compressed.
    logic r_len_done;

    t_word rv_next [8];
    t_word w_new, w_cur;
    logic [3:0] slot;

    assign slot  = r_rnd[3:0];
    assign w_cur = (r_rnd < 7'd16) ? r_w[slot] : w_new;

    sha512_round u_round (
        .i_v   (r_v),
        .i_w   (w_cur),
        .i_k   (RoundK[r_rnd]),
        .i_w16 (r_w[slot]),
        .i_w15 (r_w[slot + 4'd1]),
        .i_w7  (r_w[slot + 4'd9]),
        .i_w2  (r_w[slot + 4'd14]),
        .o_v   (rv_next),
        .o_wnew(w_new)
    );

    // Input decoding of the last word.
    logic [3:0]  cnt;
    logic [63:0] keep, lastw;
    always_comb begin
        cnt  = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
        keep = (cnt == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {cnt, 3'b000});
        lastw = (s_axis_tdata[63:0] & keep)
              | (cnt == 4'd8 ? 64'd0 : ({PadByte, 56'd0} >> {cnt, 3'b000}));
    end

    // Padding word: 0x80 if not placed yet, the length in slot 15 once slot 14 is a
    // zero padding word, else zero.
    t_word pad_w;
    always_comb begin
        if (!r_padded) pad_w = {PadByte, 56'd0};
        else if (r_pos == 4'd15 && r_zero14) pad_w = r_len;
        else pad_w = '0;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, r_h[r_oidx]};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_pos == 4'd15) n_state = S_LOAD;
                    else if (s_axis_tlast) n_state = S_PAD;
                end
            end
            S_PAD:   n_state = (r_pos == 4'd15) ? S_LOAD : S_PAD;
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: n_state = (r_rnd == 7'(Rounds - 1)) ? S_ADD : S_ROUND;
            S_ADD: begin
                if (!r_final) n_state = S_IDLE;
                else if (r_padded && r_pos == 4'd0 && r_len_done) n_state = S_OUT;
                else n_state = S_PAD;
            end
            S_OUT:   n_state = (m_axis_tready && r_oidx == 3'd7) ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_h        <= InitHash;
            r_pos      <= '0;
            r_len      <= '0;
            r_rnd      <= '0;
            r_final    <= 1'b0;
            r_padded   <= 1'b0;
            r_zero14   <= 1'b0;
            r_oidx     <= '0;
            r_len_done <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pos    <= r_pos + 4'd1;
                        r_zero14 <= 1'b0;
                        if (s_axis_tlast) begin
                            r_w[r_pos] <= lastw;
                            r_len      <= r_len + {57'd0, cnt, 3'b000};
                            r_final    <= 1'b1;
                            r_padded   <= (cnt != 4'd8);
                        end else begin
                            r_w[r_pos] <= s_axis_tdata[63:0];
                            r_len      <= r_len + 64'd64;
                        end
                    end
                end
                S_PAD: begin
                    r_w[r_pos] <= pad_w;
                    r_pos      <= r_pos + 4'd1;
                    r_padded   <= 1'b1;
                    if (r_pos == 4'd14) r_zero14 <= r_padded;
                    // the length may go only where slots 14 and 15 are both padding
                    if (r_zero14 && r_pos == 4'd15) r_len_done <= 1'b1;
                end
                S_LOAD: begin
                    r_v   <= r_h;
                    r_rnd <= '0;
                end
                S_ROUND: begin
                    r_v   <= rv_next;
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd >= 7'd16) r_w[slot] <= w_new;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_rnd <= '0;
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_h        <= InitHash;
                            r_pos      <= '0;
                            r_len      <= '0;
                            r_final    <= 1'b0;
                            r_padded   <= 1'b0;
                            r_zero14   <= 1'b0;
                            r_len_done <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("ready while compressing");
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd < 7'(Rounds)))
        else $error("round counter overrun");
    a_out_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_final && r_len_done && r_pos == 4'd0)
        else $error("digest without full padding");
`endif

endmodule
